/* design/hbic_pkg.sv */
// Shared constants, a binomial table and helper functions for the Hamming-ball index codec.
`timescale 1ns / 1ps

package hbic_pkg;

  localparam int LOW_BLOCK_BITS    = 8;
  localparam int LOW_BLOCK_WEIGHT  = 1;
  localparam int HIGH_BLOCK_BITS   = 5;
  localparam int HIGH_BLOCK_WEIGHT = 4;

  localparam int INDEX_W = 9;
  localparam int ROW_W   = 13;

  localparam int TAB_N = (LOW_BLOCK_BITS > HIGH_BLOCK_BITS) ? LOW_BLOCK_BITS : HIGH_BLOCK_BITS;
  localparam int TAB_E = TAB_N + 1;
  localparam int CW    = (INDEX_W > TAB_N + 1) ? INDEX_W : TAB_N + 1;
  localparam int WT_W  = $clog2(TAB_N + 1);

  typedef logic [CW-1:0]   cnt_t;
  typedef logic [WT_W-1:0] wt_t;

  typedef enum logic {
    OP_UNRANK = 1'b0,
    OP_RANK   = 1'b1
  } op_t;

  typedef struct packed {
    wt_t  wt;
    cnt_t res;
  } class_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic logic [TAB_E*TAB_E*CW-1:0] build_binom();
    logic [TAB_E*TAB_E*CW-1:0] t;
    cnt_t a;
    cnt_t b;
    t = '0;
    for (int n = 0; n < TAB_E; n++) begin
      t[(n*TAB_E)*CW +: CW] = cnt_t'(1);
      for (int k = 1; k <= n; k++) begin
        a = t[((n-1)*TAB_E + k - 1)*CW +: CW];
        b = t[((n-1)*TAB_E + k)*CW +: CW];
        t[(n*TAB_E + k)*CW +: CW] = a + b;
      end
    end
    return t;
  endfunction

  localparam logic [TAB_E*TAB_E*CW-1:0] BINOM_TAB = build_binom();

  function automatic cnt_t nck(int n, int k);
    if (n < 0 || k < 0 || k > n || n > TAB_N) begin
      return '0;
    end
    return BINOM_TAB[(n*TAB_E + k)*CW +: CW];
  endfunction

  function automatic cnt_t ball(int n, int r);
    cnt_t s;
    s = '0;
    for (int w = 0; w <= r; w++) begin
      s = s + nck(n, w);
    end
    return s;
  endfunction

  localparam cnt_t LOW_BALL   = ball(LOW_BLOCK_BITS, LOW_BLOCK_WEIGHT);
  localparam cnt_t HIGH_BALL  = ball(HIGH_BLOCK_BITS, HIGH_BLOCK_WEIGHT);
  localparam int   BALL_LIMIT = int'(LOW_BALL) * int'(HIGH_BALL);
  localparam int   QUO_W      = $clog2((2**INDEX_W - 1) / int'(HIGH_BALL) + 1);

  function automatic wt_t ones(int n, logic [TAB_N-1:0] bits);
    wt_t c;
    c = '0;
    for (int p = 0; p < n; p++) begin
      c = c + wt_t'(bits[p]);
    end
    return c;
  endfunction

  function automatic cnt_t cum_below(int n, wt_t wt);
    cnt_t s;
    s = '0;
    for (int v = 0; v < n; v++) begin
      if (int'(wt) > v) begin
        s = s + nck(n, v);
      end
    end
    return s;
  endfunction

  function automatic class_t pick(int n, int r, cnt_t rank);
    class_t res;
    cnt_t   cum;
    res.wt  = '0;
    res.res = rank;
    cum     = '0;
    for (int w = 1; w <= r; w++) begin
      cum = cum + nck(n, w - 1);
      if (w <= n && rank >= cum) begin
        res.wt  = wt_t'(w);
        res.res = rank - cum;
      end
    end
    return res;
  endfunction

  function automatic logic [TAB_N-1:0] walk(int n, wt_t wt, cnt_t rank);
    logic [TAB_N-1:0] pat;
    wt_t  left;
    cnt_t rem;
    cnt_t skip;
    pat  = '0;
    left = wt;
    rem  = rank;
    for (int pos = 0; pos < n; pos++) begin
      skip = nck(n - pos - 1, int'(left));
      if (left != '0 && rem >= skip) begin
        rem      = rem - skip;
        left     = left - wt_t'(1);
        pat[pos] = 1'b1;
      end
    end
    return pat;
  endfunction

endpackage

/* design/hbic_unrank.sv */
// Three-stage unrank datapath: index split, weight class pick, combinadic walk.
`timescale 1ns / 1ps

module hbic_unrank
  import hbic_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [INDEX_W-1:0] index_in,
  output logic [ROW_W-1:0]   row,
  output logic               fail
);

  localparam int DW = INDEX_W + QUO_W;
  localparam logic [DW-1:0] DIV_EXT = DW'(HIGH_BALL);

  logic [DW-1:0]    rem;
  logic [QUO_W-1:0] quo_nxt;
  cnt_t             rem_nxt;
  logic             fail1_nxt;

  logic [QUO_W-1:0] quo_r;
  cnt_t             rem_r;
  logic             fail1_r;

  class_t           cls0_nxt, cls1_nxt;
  class_t           cls0_r, cls1_r;
  logic             fail2_r;

  logic [TAB_N-1:0] pat0, pat1;
  logic [ROW_W-1:0] row_nxt;
  logic [ROW_W-1:0] row_r;
  logic             fail3_r;

  always_comb begin
    rem     = DW'(index_in);
    quo_nxt = '0;
    for (int j = QUO_W - 1; j >= 0; j--) begin
      if (rem >= (DIV_EXT << j)) begin
        rem        = rem - (DIV_EXT << j);
        quo_nxt[j] = 1'b1;
      end
    end
    rem_nxt   = cnt_t'(rem);
    fail1_nxt = int'(index_in) >= BALL_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      quo_r   <= quo_nxt;
      rem_r   <= rem_nxt;
      fail1_r <= fail1_nxt;
    end
  end

  always_comb begin
    cls0_nxt = pick(LOW_BLOCK_BITS, LOW_BLOCK_WEIGHT, cnt_t'(quo_r));
    cls1_nxt = pick(HIGH_BLOCK_BITS, HIGH_BLOCK_WEIGHT, rem_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      cls0_r  <= cls0_nxt;
      cls1_r  <= cls1_nxt;
      fail2_r <= fail1_r;
    end
  end

  always_comb begin
    pat0    = walk(LOW_BLOCK_BITS, cls0_r.wt, cls0_r.res);
    pat1    = walk(HIGH_BLOCK_BITS, cls1_r.wt, cls1_r.res);
    row_nxt = ROW_W'({pat1[HIGH_BLOCK_BITS-1:0], pat0[LOW_BLOCK_BITS-1:0]});
    if (fail2_r) begin
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      row_r   <= row_nxt;
      fail3_r <= fail2_r;
    end
  end

  assign row  = row_r;
  assign fail = fail3_r;

endmodule

/* design/hbic_rank.sv */
// Three-stage rank datapath: weight count, combinadic terms, sum and index combine.
`timescale 1ns / 1ps

module hbic_rank
  import hbic_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [ROW_W-1:0]   row_in,
  output logic [INDEX_W-1:0] index,
  output logic               fail
);

  localparam int PW = 2 * CW;

  logic [LOW_BLOCK_BITS-1:0]  sub0;
  logic [HIGH_BLOCK_BITS-1:0] sub1;
  wt_t                        wt0_nxt, wt1_nxt;
  logic                       fail1_nxt;

  logic [LOW_BLOCK_BITS-1:0]  bits0_r;
  logic [HIGH_BLOCK_BITS-1:0] bits1_r;
  wt_t                        wt0_r, wt1_r;
  cnt_t                       off0_r, off1_r;
  logic                       fail1_r;

  logic [LOW_BLOCK_BITS-1:0][CW-1:0]  term0_nxt, term0_r;
  logic [HIGH_BLOCK_BITS-1:0][CW-1:0] term1_nxt, term1_r;
  cnt_t                               off0b_r, off1b_r;
  logic                               fail2_r;
  wt_t                                cnt0, cnt1;

  cnt_t    r0_nxt, r1_nxt;
  cnt_t    r0_r, r1_r;
  logic    fail3_r;
  logic [PW-1:0] idx;
  logic          over;

  always_comb begin
    sub0      = row_in[LOW_BLOCK_BITS-1:0];
    sub1      = row_in[LOW_BLOCK_BITS+HIGH_BLOCK_BITS-1:LOW_BLOCK_BITS];
    wt0_nxt   = ones(LOW_BLOCK_BITS, TAB_N'(sub0));
    wt1_nxt   = ones(HIGH_BLOCK_BITS, TAB_N'(sub1));
    fail1_nxt = (int'(wt0_nxt) > LOW_BLOCK_WEIGHT) || (int'(wt1_nxt) > HIGH_BLOCK_WEIGHT);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      bits0_r <= sub0;
      bits1_r <= sub1;
      wt0_r   <= wt0_nxt;
      wt1_r   <= wt1_nxt;
      off0_r  <= cum_below(LOW_BLOCK_BITS, wt0_nxt);
      off1_r  <= cum_below(HIGH_BLOCK_BITS, wt1_nxt);
      fail1_r <= fail1_nxt;
    end
  end

  always_comb begin
    cnt0 = '0;
    for (int p = 0; p < LOW_BLOCK_BITS; p++) begin
      term0_nxt[p] = bits0_r[p] ? nck(LOW_BLOCK_BITS - p - 1, int'(wt0_r) - int'(cnt0)) : '0;
      cnt0 = cnt0 + wt_t'(bits0_r[p]);
    end
    cnt1 = '0;
    for (int p = 0; p < HIGH_BLOCK_BITS; p++) begin
      term1_nxt[p] = bits1_r[p] ? nck(HIGH_BLOCK_BITS - p - 1, int'(wt1_r) - int'(cnt1)) : '0;
      cnt1 = cnt1 + wt_t'(bits1_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      term0_r <= term0_nxt;
      term1_r <= term1_nxt;
      off0b_r <= off0_r;
      off1b_r <= off1_r;
      fail2_r <= fail1_r;
    end
  end

  always_comb begin
    r0_nxt = off0b_r;
    for (int p = 0; p < LOW_BLOCK_BITS; p++) begin
      r0_nxt = r0_nxt + term0_r[p];
    end
    r1_nxt = off1b_r;
    for (int p = 0; p < HIGH_BLOCK_BITS; p++) begin
      r1_nxt = r1_nxt + term1_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      r0_r    <= r0_nxt;
      r1_r    <= r1_nxt;
      fail3_r <= fail2_r;
    end
  end

  always_comb begin
    idx   = PW'(r0_r) * PW'(HIGH_BALL) + PW'(r1_r);
    over  = idx >= PW'(BALL_LIMIT);
    fail  = fail3_r || over;
    index = fail ? '0 : idx[INDEX_W-1:0];
  end

endmodule

/* design/hamming_ball_index_codec_unit.sv */
// Top level of the Hamming-ball index codec: stage control, opcode pipe and result register.
`timescale 1ns / 1ps

// Converts a block position index into a two-sub-block witness row (opcode 0)
// or a witness row back into its index (opcode 1).
// Input channel: in_valid/in_ready carry one word of opcode, position index and row.
// Result channel: out_valid/out_ready carry one word of index, row and fail flag.
// Four register stages: index split or weight count, weight class pick or
// combinadic terms, combinadic walk or rank sum, then the result register.
// A word accepted into the first stage moves through the second and third stages
// and then the result register; a stalled receiver can hold it in any stage.
// Throughput: one word per cycle unless the receiver stalls; each stage is a single pass of its logic.
// When the receiver stalls, full stages hold and in_ready drops only once every
// stage is occupied; no word is lost or repeated.
// Reset clears all stage valid bits; the block needs no warm-up after reset.
module hamming_ball_index_codec_unit
  import hbic_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [INDEX_W-1:0] in_position_index,
  input  logic [ROW_W-1:0]   in_witness_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_index_out,
  output logic [ROW_W-1:0]   out_row_out,
  output logic               out_fail
);

  logic rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  op_t  op1_r, op2_r, op3_r;

  logic [ROW_W-1:0]   unrank_row;
  logic               unrank_fail;
  logic [INDEX_W-1:0] rank_index;
  logic               rank_fail;

  logic [INDEX_W-1:0] index_nxt, index_r;
  logic [ROW_W-1:0]   row_nxt, row_r;
  logic               fail_nxt, fail_r;

  always_comb begin
    rdy4  = !out_valid_r || out_ready;
    rdy3  = !v3_r || rdy4;
    rdy2  = !v2_r || rdy3;
    rdy1  = !v1_r || rdy2;
    en.s1 = rdy1;
    en.s2 = rdy2;
    en.s3 = rdy3;
  end

  always_comb begin
    v1_nxt        = rdy1 ? in_valid : v1_r;
    v2_nxt        = rdy2 ? v1_r : v2_r;
    v3_nxt        = rdy3 ? v2_r : v3_r;
    out_valid_nxt = rdy4 ? v3_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r <= op_t'(in_opcode);
    end
    if (rdy2) begin
      op2_r <= op1_r;
    end
    if (rdy3) begin
      op3_r <= op2_r;
    end
  end

  hbic_unrank u_unrank (
    .clk      (clk),
    .en       (en),
    .index_in (in_position_index),
    .row      (unrank_row),
    .fail     (unrank_fail)
  );

  hbic_rank u_rank (
    .clk    (clk),
    .en     (en),
    .row_in (in_witness_row),
    .index  (rank_index),
    .fail   (rank_fail)
  );

  always_comb begin
    if (op3_r == OP_RANK) begin
      index_nxt = rank_index;
      row_nxt   = '0;
      fail_nxt  = rank_fail;
    end else begin
      index_nxt = '0;
      row_nxt   = unrank_row;
      fail_nxt  = unrank_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      index_r <= index_nxt;
      row_r   <= row_nxt;
      fail_r  <= fail_nxt;
    end
  end

  assign in_ready      = rdy1;
  assign out_valid     = out_valid_r;
  assign out_index_out = index_r;
  assign out_row_out   = row_r;
  assign out_fail      = fail_r;

endmodule
